/* rtl/sopt_pkg.sv */
`timescale 1ns / 1ps
package sopt_pkg;

  localparam int MAX_SPHERES = 512;
  localparam int COORD_BITS  = 20;
  localparam int RAD_W       = 16;
  localparam int ADDR_W      = $clog2(MAX_SPHERES);
  localparam int CNT_W       = 10;

  // entry word in the sphere memory: x, y, z, radius
  localparam int ENTRY_W = 3 * COORD_BITS + RAD_W;

  // distance arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int D2_W   = SQ_W + 2;
  localparam int RS_W   = RAD_W + 1;
  localparam int RS2_W  = 2 * RS_W;
  localparam int CMP_W  = (D2_W > RS2_W) ? D2_W : RS2_W;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [RAD_W-1:0]             r;
  } sphere_t;

  // compare pipeline status toward the controller
  typedef struct packed {
    logic busy;
    logic valid;
    logic hit;
  } cmp_t;

  // magnitude of a - b, exact in one extra bit
  function automatic logic [DIFF_W-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

/* rtl/sopt_in_if.sv */
`timescale 1ns / 1ps
interface sopt_in_if import sopt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic [RAD_W-1:0]             sphere_radius;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

/* rtl/sopt_out_if.sv */
`timescale 1ns / 1ps
interface sopt_out_if import sopt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             placed;
  logic [1:0]       status;
  logic [CNT_W-1:0] stored_count;

  modport source (output valid, placed, status, stored_count, input ready);
  modport sink (input valid, placed, status, stored_count, output ready);
endinterface

/* rtl/sopt_ram.sv */
`timescale 1ns / 1ps
module sopt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sopt_dist.sv */
`timescale 1ns / 1ps
module sopt_dist import sopt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    flush,
  input  sphere_t cand,
  input  sphere_t ent,
  input  logic    ent_valid,
  output cmp_t    cmp
);

  // stage 1: coordinate distances and radius sum
  logic              v1;
  logic [DIFF_W-1:0] ax, ay, az;
  logic [RS_W-1:0]   rs;
  // stage 2: squares
  logic              v2;
  logic [SQ_W-1:0]   sx, sy, sz;
  logic [RS2_W-1:0]  rs2_a;
  // stage 3: distance sum
  logic              v3;
  logic [D2_W-1:0]   d2;
  logic [RS2_W-1:0]  rs2_b;
  // stage 4: compare
  logic              v4;
  logic              hit;

  logic [2*DIFF_W-1:0] px, py, pz;
  logic [RS2_W-1:0]    prs;

  always_comb begin
    px  = ax * ax;
    py  = ay * ay;
    pz  = az * az;
    prs = rs * rs;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ent_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    ax    <= abs_diff(cand.x, ent.x);
    ay    <= abs_diff(cand.y, ent.y);
    az    <= abs_diff(cand.z, ent.z);
    rs    <= RS_W'(cand.r) + RS_W'(ent.r);
    sx    <= px[SQ_W-1:0];
    sy    <= py[SQ_W-1:0];
    sz    <= pz[SQ_W-1:0];
    rs2_a <= prs;
    d2    <= D2_W'(sx) + D2_W'(sy) + D2_W'(sz);
    rs2_b <= rs2_a;
    hit   <= CMP_W'(d2) < CMP_W'(rs2_b);
  end

  assign cmp.busy  = v1 | v2 | v3;
  assign cmp.valid = v4;
  assign cmp.hit   = hit;

endmodule

/* rtl/sphere_overlap_placement_table_top.sv */
`timescale 1ns / 1ps
// Sphere placement table. Each request on cand carries a candidate sphere
// (signed Q12.8 center, unsigned Q8.8 radius) and yields exactly one result on
// res. The candidate is tested against every stored sphere; it overlaps when
// the squared center distance is strictly below the squared radius sum, so
// touching spheres do not overlap. A candidate that overlaps nothing is
// appended (placed = 1, status 0), an overlapping one is rejected (status 1),
// and once 512 spheres are stored every candidate is rejected with status 2.
// stored_count is the table size after the request. All arithmetic is exact.
// The table sits in a single memory with one read port, so the scan reads one
// entry per cycle, followed by the memory read latency and the four-stage
// compare pipeline; a full table rejects the candidate without a scan. The
// scan stops at the first overlap. A new request is taken while the previous
// result still waits on res; the one after that waits in the finish step
// until res is free. Reset empties the table at once.
module sphere_overlap_placement_table_top import sopt_pkg::*; (
  input logic clk,
  input logic rst,
  sopt_in_if.sink    cand,
  sopt_out_if.source res
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;     // spheres stored
  logic [CNT_W-1:0] idx;       // next entry to read
  logic             rd_vld;    // memory read data valid this cycle
  sphere_t          cand_q;
  status_t          res_status;

  logic [ENTRY_W-1:0] rdata;
  sphere_t            ent;
  cmp_t               cmp;
  logic               issue;
  logic               hit;
  logic               scan_done;
  logic               ram_we;

  // one entry read per cycle while entries remain
  assign issue = (state == SCAN) && (idx < count);
  assign hit   = cmp.valid && cmp.hit;
  // all entries read and compared with no overlap: append the candidate
  assign scan_done = (state == SCAN) && !hit && (idx == count) && !rd_vld && !cmp.busy;
  // the write only happens once no read is in flight, so no forwarding needed
  assign ram_we = scan_done;

  assign ent        = sphere_t'(rdata);
  assign cand.ready = (state == IDLE);

  sopt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SPHERES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (ENTRY_W'(cand_q)),
    .re    (issue),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // compare pipeline, cleared on the first overlap
  sopt_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .flush     (hit),
    .cand      (cand_q),
    .ent       (ent),
    .ent_valid (rd_vld),
    .cmp       (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      // a hit drops the read still in flight
      rd_vld <= issue && !hit;
      if (res.valid && res.ready && state != FIN) begin
        res.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cand.valid) begin
            cand_q.x <= cand.center_x;
            cand_q.y <= cand.center_y;
            cand_q.z <= cand.center_z;
            cand_q.r <= cand.sphere_radius;
            idx      <= '0;
            if (count == CNT_W'(MAX_SPHERES)) begin
              res_status <= ST_FULL;
              state      <= FIN;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (hit) begin
            res_status <= ST_OVERLAP;
            state      <= FIN;
          end else if (scan_done) begin
            count      <= count + 1'b1;
            res_status <= ST_PLACED;
            state      <= FIN;
          end
        end
        FIN: begin
          // wait for the result register to free up
          if (!res.valid || res.ready) begin
            res.valid        <= 1'b1;
            res.placed       <= (res_status == ST_PLACED);
            res.status       <= res_status;
            res.stored_count <= count;
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SPHERES))
    else $error("table count beyond capacity");

  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !rd_vld && !cmp.busy && !issue)
    else $error("table write while a read is in flight");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !ram_we |=> count == $past(count))
    else $error("table count changed without a write");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp.valid |-> state == SCAN)
    else $error("compare result outside of a scan");

  a_res_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == FIN))
    else $error("result raised outside of the finish step");
`endif

endmodule

/* sim/sphere_overlap_placement_table_top_tb.sv */
`timescale 1ns / 1ps
module sphere_overlap_placement_table_top_tb;
  import sopt_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD   = 400;
  localparam int MIXED_COUNT = 40;
  localparam int FULL_COUNT  = 12;

  typedef struct packed {
    logic             placed;
    status_t          status;
    logic [CNT_W-1:0] count;
  } placement_result_t;

  // mirror of the sphere table plus the answers still owed on res
  class placement_scoreboard;
    sphere_t           spheres[$];
    placement_result_t owed_q[$];
    int                errors;
    int                n_placed;
    int                n_overlap;
    int                n_full;

    function bit spheres_overlap(sphere_t a, sphere_t b);
      longint ca[3];
      longint cb[3];
      longint d;
      longint d2;
      longint rs;
      ca[0] = $signed(a.x);
      ca[1] = $signed(a.y);
      ca[2] = $signed(a.z);
      cb[0] = $signed(b.x);
      cb[1] = $signed(b.y);
      cb[2] = $signed(b.z);
      d2 = 0;
      for (int k = 0; k < 3; k++) begin
        d = ca[k] - cb[k];
        if (d < 0) d = -d;
        d2 += d * d;
      end
      rs = longint'(a.r) + longint'(b.r);
      // touching is not an overlap
      return d2 < rs * rs;
    endfunction

    function void note_request(sphere_t s);
      placement_result_t e;
      e.status = ST_PLACED;
      if (spheres.size() >= MAX_SPHERES) begin
        e.status = ST_FULL;
      end else begin
        foreach (spheres[i]) begin
          if (spheres_overlap(s, spheres[i])) begin
            e.status = ST_OVERLAP;
            break;
          end
        end
      end
      if (e.status == ST_PLACED) spheres.push_back(s);
      e.placed = (e.status == ST_PLACED);
      e.count  = CNT_W'(spheres.size());
      owed_q.push_back(e);
      case (e.status)
        ST_PLACED:  n_placed++;
        ST_OVERLAP: n_overlap++;
        default:    n_full++;
      endcase
    endfunction

    function void check_result(logic placed, logic [1:0] status, logic [CNT_W-1:0] count);
      placement_result_t e;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: placed %0d status %0d stored_count %0d",
               placed, status, count);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (placed !== e.placed) begin
        $error("placed mismatch: expected %0d, got %0d", e.placed, placed);
        errors++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("stored_count mismatch: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sopt_in_if  cand_if ();
  sopt_out_if res_if ();

  sphere_overlap_placement_table_top uut (
    .clk  (clk),
    .rst  (rst),
    .cand (cand_if),
    .res  (res_if)
  );

  placement_scoreboard sb = new();

  bit  long_hold_req = 1'b0;
  bit  no_stall      = 1'b0;
  int  send_calm     = 0;
  int  n_sent        = 0;
  int  cycle_count   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // results are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.placed, res_if.status, res_if.stored_count);
  end

  // receiver: random stall bursts, calm stretches, one long hold on request
  initial begin : receiver
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (no_stall || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            stall_left = $urandom_range(1, 17) - 1;
            res_if.ready <= 1'b0;
          end
          2: begin
            calm_left = $urandom_range(20, 80);
            res_if.ready <= 1'b1;
          end
          default: res_if.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic sphere_t sph(input int x, input int y, input int z, input int r);
    sphere_t s;
    s.x = COORD_BITS'(x);
    s.y = COORD_BITS'(y);
    s.z = COORD_BITS'(z);
    s.r = RAD_W'(r);
    return s;
  endfunction

  function automatic sphere_t random_sphere();
    sphere_t s;
    s.x = COORD_BITS'($urandom());
    s.y = COORD_BITS'($urandom());
    s.z = COORD_BITS'($urandom());
    case ($urandom_range(0, 5))
      0:       s.r = '0;
      1:       s.r = '1;
      default: s.r = RAD_W'($urandom());
    endcase
    return s;
  endfunction

  // move a coordinate by +-off, wrapping at the field width
  function automatic logic [COORD_BITS-1:0] shift_coord(logic signed [COORD_BITS-1:0] c,
                                                         longint off);
    if ($urandom_range(0, 1)) off = -off;
    return COORD_BITS'(longint'(c) + off);
  endfunction

  // candidate placed right around the overlap boundary of a stored sphere
  function automatic sphere_t near_sphere();
    sphere_t base;
    sphere_t s;
    longint  rs;
    longint  off;
    longint  k;
    if (sb.spheres.size() == 0) return random_sphere();
    base = sb.spheres[$urandom_range(0, sb.spheres.size() - 1)];
    s = base;
    if ($urandom_range(0, 4) == 0) begin
      // 3-4-5 offset in the x-y plane, radius sum 5k give or take one
      k = $urandom_range((base.r + 4) / 5, (base.r + 65535) / 5);
      s.r = RAD_W'(5 * k - base.r);
      case ($urandom_range(0, 2))
        0:       if (s.r != '0) s.r = s.r - 1'b1;
        1:       if (s.r != '1) s.r = s.r + 1'b1;
        default: ;
      endcase
      s.x = shift_coord(base.x, 3 * k);
      s.y = shift_coord(base.y, 4 * k);
    end else begin
      s.r = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(0, 2000));
      rs = longint'(s.r) + longint'(base.r);
      case ($urandom_range(0, 3))
        0:       off = (rs > 0) ? rs - 1 : 0;
        1:       off = rs;
        2:       off = rs + 1;
        default: off = $urandom_range(0, int'(2 * rs));
      endcase
      case ($urandom_range(0, 2))
        0:       s.x = shift_coord(base.x, off);
        1:       s.y = shift_coord(base.y, off);
        default: s.z = shift_coord(base.z, off);
      endcase
    end
    return s;
  endfunction

  task automatic send_sphere(input sphere_t s);
    @(negedge clk);
    cand_if.valid         <= 1'b1;
    cand_if.center_x      <= s.x;
    cand_if.center_y      <= s.y;
    cand_if.center_z      <= s.z;
    cand_if.sphere_radius <= s.r;
    @(posedge clk);
    while (!cand_if.ready) @(posedge clk);
    sb.note_request(s);
    n_sent++;
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      cand_if.valid         <= 1'b0;
      cand_if.center_x      <= COORD_BITS'($urandom());
      cand_if.center_y      <= COORD_BITS'($urandom());
      cand_if.center_z      <= COORD_BITS'($urandom());
      cand_if.sphere_radius <= RAD_W'($urandom());
    end
  endtask

  // random sender gaps between requests
  task automatic pace();
    if (no_stall) return;
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    idle($urandom_range(1, 17));
        2:       send_calm = $urandom_range(15, 60);
        default: ;
      endcase
    end
  endtask

  // drop valid first so the last request is not taken twice
  task automatic wait_for_drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cand_if.valid         = 1'b0;
    cand_if.center_x      = '0;
    cand_if.center_y      = '0;
    cand_if.center_z      = '0;
    cand_if.sphere_radius = '0;
    res_if.ready          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero radii, touching and off-by-one spheres, field extremes
    send_sphere(sph(0, 0, 0, 0));
    send_sphere(sph(0, 0, 0, 0));                 // same center, both radius zero
    send_sphere(sph(0, 0, 0, 1));                 // coincident with a nonzero radius
    send_sphere(sph(524287, 524287, 524287, 65535));
    send_sphere(sph(-524288, -524288, -524288, 65535));
    pace();
    send_sphere(sph(300, 400, 0, 500));           // touches the origin spheres
    send_sphere(sph(-300, -400, 0, 500));         // touches the origin spheres and the previous one
    send_sphere(sph(0, 0, 600, 601));             // overlaps by one
    send_sphere(sph(200000, 0, 0, 1000));
    send_sphere(sph(200000, 0, 2000, 1000));      // touching along z
    pace();
    send_sphere(sph(200000, 0, -1999, 1000));     // overlap by one along z
    send_sphere(sph(200000, 0, -2001, 999));      // near miss
    send_sphere(sph(-524288, -524288, -393219, 65535));  // max radii, just overlapping
    send_sphere(sph(-524288, -524288, -393218, 65535));  // max radii, touching
    send_sphere(sph(-1, -1, -1, 32768));
    send_sphere(sph(524287, -524288, 0, 65535));
    send_sphere(sph(-524288, 524287, 524287, 0));
    send_sphere(sph(524287, 524287, -524288, 65535));
    send_sphere(sph(174762, -174763, 349525, 43690));
    send_sphere(sph(-349526, 349525, -174763, 21845));
    wait_for_drain();

    // mixed traffic: boundary probes against stored spheres plus noise
    for (int n = 0; n < MIXED_COUNT; n++) begin
      if (n == 10) long_hold_req = 1'b1;   // back up the block behind a stalled res
      if (n == 30) wait_for_drain();
      send_sphere(($urandom_range(0, 99) < 55) ? near_sphere() : random_sphere());
      pace();
    end

    // fill the table; deep scans with late hits along the way
    while (sb.spheres.size() < MAX_SPHERES) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sphere(near_sphere());
      end else begin
        send_sphere(sph($urandom(), $urandom(), $urandom(), $urandom_range(0, 511)));
      end
      pace();
    end

    // full table, back to back with no stalls on either side
    no_stall = 1'b1;
    send_sphere(sph(0, 0, 0, 0));
    send_sphere(sph(524287, -524288, 524287, 65535));
    for (int n = 2; n < FULL_COUNT; n++)
      send_sphere(($urandom_range(0, 1) == 0) ? near_sphere() : random_sphere());
    idle(1);

    wait_for_drain();
    repeat (600) @(posedge clk);   // catch any stray result after the last one

    $display("summary: %0d requests, %0d placed, %0d rejected as overlapping, %0d refused",
             n_sent, sb.n_placed, sb.n_overlap, sb.n_full);
    $display("summary: table ended with %0d spheres after %0d cycles",
             sb.spheres.size(), cycle_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
